@@ design/pspm_pkg.sv @@
// Package for the Pauli string product core: channel layout constants and bit-count helpers.
package pspm_pkg;

   // Width of every qubit word field on the channels
   localparam int FIELD_BITS = 64;

   // Request tdata layout, lowest bit first
   localparam int REQ_LX_LSB    = 0;
   localparam int REQ_LZ_LSB    = REQ_LX_LSB + FIELD_BITS;
   localparam int REQ_RX_LSB    = REQ_LZ_LSB + FIELD_BITS;
   localparam int REQ_RZ_LSB    = REQ_RX_LSB + FIELD_BITS;
   localparam int REQ_LSIGN_BIT = REQ_RZ_LSB + FIELD_BITS;
   localparam int REQ_RSIGN_BIT = REQ_LSIGN_BIT + 1;
   localparam int REQ_USED_BITS = REQ_RSIGN_BIT + 1;
   localparam int REQ_TDATA_BITS = ((REQ_USED_BITS + 7) / 8) * 8;

   // Response tdata layout, lowest bit first
   localparam int RSP_PX_LSB       = 0;
   localparam int RSP_PZ_LSB       = RSP_PX_LSB + FIELD_BITS;
   localparam int RSP_PHASE_LSB    = RSP_PZ_LSB + FIELD_BITS;
   localparam int PHASE_BITS       = 2;
   localparam int RSP_SIGN_BIT     = RSP_PHASE_LSB + PHASE_BITS;
   localparam int RSP_COMMUTE_BIT  = RSP_SIGN_BIT + 1;
   localparam int RSP_USED_BITS    = RSP_COMMUTE_BIT + 1;
   localparam int RSP_TDATA_BITS   = ((RSP_USED_BITS + 7) / 8) * 8;

   typedef logic [FIELD_BITS-1:0] word_type;
   typedef logic [PHASE_BITS-1:0] phase_type;

   // Population count mod 4 of a word as a balanced tree of 2-bit adders
   function automatic phase_type popcount_mod4(input word_type v);
      phase_type acc [FIELD_BITS];
      for (int i = 0; i < FIELD_BITS; i++) begin
         acc[i] = {1'b0, v[i]};
      end
      for (int s = FIELD_BITS >> 1; s >= 1; s = s >> 1) begin
         for (int i = 0; i < s; i++) begin
            acc[i] = PHASE_BITS'(acc[2*i] + acc[2*i+1]);
         end
      end
      return acc[0];
   endfunction

endpackage

@@ design/pauli_string_multiply_phase_core.sv @@
// Top level of the Pauli string product core with per-lane phase counters.
// Multiplies a left Pauli string by a right one, one word of qubits per transfer.
// Each request returns one response: product X/Z words (left xor right) and, on
// the word marked tlast, the power of i of the product scalar, the updated left
// sign and a commute flag; the per-lane mod-4 counters clear after that word.
// Throughput is one word per clock unless the response side stalls: an input
// register feeds a few gates of lane update plus a 6-level mod-4 popcount tree,
// whose result lands in the output register. Only the low min(WORD_BITS, 64)
// lanes are used; higher input bits are ignored and read back as zero.
module pauli_string_multiply_phase_core #(
   parameter int WORD_BITS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request: left_x_word, left_z_word, right_x_word, right_z_word,
   //          left_sign, right_sign, zero pad (low bit first)
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pspm_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   input  logic                                req_tlast,   // last_word
   // Response: product_x_word, product_z_word, phase_exponent, product_sign,
   //           strings_commute, zero pad (low bit first)
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pspm_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic                                rsp_tlast    // is_last
);
   import pspm_pkg::*;

   localparam int LANES = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;
   localparam word_type LANE_MASK =
      (LANES == FIELD_BITS) ? '1 : ((word_type'(1) << LANES) - word_type'(1));

   // Input stage
   logic                  s1_valid_ff, s1_valid_in;
   logic [LANES-1:0]      s1_lx_ff, s1_lz_ff, s1_rx_ff, s1_rz_ff;
   logic                  s1_lsign_ff, s1_rsign_ff, s1_last_ff;
   // Counter planes
   logic [LANES-1:0]      cnt_low_ff, cnt_low_in, cnt_high_ff, cnt_high_in;
   // Output stage
   logic                  out_valid_ff, out_valid_in;
   word_type              out_px_ff, out_pz_ff, out_px_in, out_pz_in;
   phase_type             out_phase_ff, out_phase_in;
   logic                  out_sign_ff, out_sign_in;
   logic                  out_commute_ff, out_commute_in;
   logic                  out_last_ff;

   logic                  req_xfer, s1_adv, out_free;
   logic [LANES-1:0]      nx, nz, xz, anti, upd_low, upd_high;
   phase_type             phase;

   // Handshake and stage movement
   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_xfer   = req_tvalid && req_tready;

   assign s1_valid_in  = req_xfer || (s1_valid_ff && !out_free);
   assign out_valid_in = s1_adv || (out_valid_ff && !rsp_tready);

   // Lane update and phase for the word in the input stage
   always_comb begin
      nx       = s1_lx_ff ^ s1_rx_ff;
      nz       = s1_lz_ff ^ s1_rz_ff;
      xz       = s1_lx_ff & s1_rz_ff;
      anti     = (s1_rx_ff & s1_lz_ff) ^ xz;
      upd_high = cnt_high_ff ^ ((cnt_low_ff ^ nx ^ nz ^ xz) & anti);
      upd_low  = cnt_low_ff ^ anti;
      phase    = popcount_mod4(word_type'(upd_low))
               ^ {(^upd_high) ^ s1_rsign_ff, 1'b0};

      out_px_in = word_type'(nx);
      out_pz_in = word_type'(nz);
      if (s1_last_ff) begin
         out_phase_in   = phase;
         out_sign_in    = s1_lsign_ff ^ phase[1];
         out_commute_in = !phase[0];
         cnt_low_in     = '0;
         cnt_high_in    = '0;
      end else begin
         out_phase_in   = '0;
         out_sign_in    = 1'b0;
         out_commute_in = 1'b0;
         cnt_low_in     = upd_low;
         cnt_high_in    = upd_high;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cnt_low_ff   <= '0;
         cnt_high_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_adv) begin
            cnt_low_ff  <= cnt_low_in;
            cnt_high_ff <= cnt_high_in;
         end
      end
   end

   // Input payload register
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_lx_ff    <= req_tdata[REQ_LX_LSB +: LANES];
         s1_lz_ff    <= req_tdata[REQ_LZ_LSB +: LANES];
         s1_rx_ff    <= req_tdata[REQ_RX_LSB +: LANES];
         s1_rz_ff    <= req_tdata[REQ_RZ_LSB +: LANES];
         s1_lsign_ff <= req_tdata[REQ_LSIGN_BIT];
         s1_rsign_ff <= req_tdata[REQ_RSIGN_BIT];
         s1_last_ff  <= req_tlast;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_px_ff      <= out_px_in;
         out_pz_ff      <= out_pz_in;
         out_phase_ff   <= out_phase_in;
         out_sign_ff    <= out_sign_in;
         out_commute_ff <= out_commute_in;
         out_last_ff    <= s1_last_ff;
      end
   end

   // Response packing
   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[RSP_PX_LSB +: FIELD_BITS]    = out_px_ff;
      rsp_tdata[RSP_PZ_LSB +: FIELD_BITS]    = out_pz_ff;
      rsp_tdata[RSP_PHASE_LSB +: PHASE_BITS] = out_phase_ff;
      rsp_tdata[RSP_SIGN_BIT]                = out_sign_ff;
      rsp_tdata[RSP_COMMUTE_BIT]             = out_commute_ff;
   end
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTHESIS
   // Counters are empty after the last word moves on
   a_cnt_clear: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_last_ff) |=> (cnt_low_ff == '0 && cnt_high_ff == '0))
      else $error("phase counters not cleared after last word");

   // Phase fields stay zero on words that are not last
   a_nonlast_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_last_ff) |->
         (out_phase_ff == '0 && !out_sign_ff && !out_commute_ff))
      else $error("phase fields set on a word that is not last");

   // Commute flag follows the low phase bit on the last word
   a_commute: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff) |-> (out_commute_ff == !out_phase_ff[0]))
      else $error("commute flag disagrees with phase");

   // Lanes above the word width read back as zero
   a_lane_mask: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_px_ff & ~LANE_MASK) == '0 && (out_pz_ff & ~LANE_MASK) == '0))
      else $error("product bits set above the word width");

   // An empty input stage always takes a new word
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("input stage empty but not ready");
`endif

endmodule

@@ dv/pspm_product_checker.sv @@
// Checker for the Pauli string product core: watches both channels, predicts and compares.
module pspm_product_checker #(
   parameter int WORD_BITS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [pspm_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   input  logic                                req_tlast,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [pspm_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input  logic                                rsp_tlast,
   output int                                  mismatch_count,
   output int                                  outstanding
);
   import pspm_pkg::*;

   localparam int LANES = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;
   localparam word_type LANE_MASK =
      (LANES >= FIELD_BITS) ? '1 : word_type'((word_type'(1) << LANES) - 1);

   typedef struct packed {
      word_type  px;
      word_type  pz;
      phase_type phase;
      logic      sign;
      logic      commute;
      logic      last;
   } product_type;

   // Per-lane mod-4 counters of anticommuting positions, low and high planes
   word_type    count_low;
   word_type    count_high;
   product_type expected_products[$];
   int          error_total;

   assign mismatch_count = error_total;

   // Number of set bits, wrapped to two bits
   function automatic phase_type ones_mod4(input word_type v);
      phase_type n;
      n = '0;
      for (int i = 0; i < FIELD_BITS; i++) n = n + phase_type'(v[i]);
      return n;
   endfunction

   // Product of one word pair; updates the lane counters and clears them on the last word
   function automatic product_type multiply_word(input word_type lx_in, input word_type lz_in,
                                                 input word_type rx_in, input word_type rz_in,
                                                 input logic lsign, input logic rsign,
                                                 input logic last);
      word_type    lx, lz, rx, rz, xz, anti;
      product_type p;
      phase_type   ph;
      lx = lx_in & LANE_MASK;
      lz = lz_in & LANE_MASK;
      rx = rx_in & LANE_MASK;
      rz = rz_in & LANE_MASK;
      p = '0;
      p.px = lx ^ rx;
      p.pz = lz ^ rz;
      p.last = last;
      xz = lx & rz;
      anti = (rx & lz) ^ xz;
      count_high = count_high ^ ((count_low ^ p.px ^ p.pz ^ xz) & anti);
      count_low  = count_low ^ anti;
      if (last) begin
         ph = ones_mod4(count_low) ^ {^count_high, 1'b0} ^ {rsign, 1'b0};
         p.phase = ph;
         p.sign = lsign ^ ph[1];
         p.commute = ~ph[0];
         count_low = '0;
         count_high = '0;
      end
      return p;
   endfunction

   task automatic check_field(input string name, input word_type want, input word_type got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         error_total++;
      end
   endtask

   // Predict on each request transfer, compare on each response transfer
   always @(posedge clock) begin
      product_type want;
      if (reset) begin
         count_low = '0;
         count_high = '0;
         expected_products.delete();
         outstanding <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_products.push_back(multiply_word(
               req_tdata[REQ_LX_LSB +: FIELD_BITS], req_tdata[REQ_LZ_LSB +: FIELD_BITS],
               req_tdata[REQ_RX_LSB +: FIELD_BITS], req_tdata[REQ_RZ_LSB +: FIELD_BITS],
               req_tdata[REQ_LSIGN_BIT], req_tdata[REQ_RSIGN_BIT], req_tlast));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_products.size() == 0) begin
               $error("unexpected response transfer: tdata %h, tlast %b", rsp_tdata, rsp_tlast);
               error_total++;
            end else begin
               want = expected_products.pop_front();
               check_field("product_x_word", want.px, rsp_tdata[RSP_PX_LSB +: FIELD_BITS]);
               check_field("product_z_word", want.pz, rsp_tdata[RSP_PZ_LSB +: FIELD_BITS]);
               check_field("phase_exponent", word_type'(want.phase),
                           word_type'(rsp_tdata[RSP_PHASE_LSB +: PHASE_BITS]));
               check_field("product_sign", word_type'(want.sign),
                           word_type'(rsp_tdata[RSP_SIGN_BIT]));
               check_field("strings_commute", word_type'(want.commute),
                           word_type'(rsp_tdata[RSP_COMMUTE_BIT]));
               check_field("is_last", word_type'(want.last), word_type'(rsp_tlast));
            end
         end
         outstanding <= expected_products.size();
      end
   end

   initial begin
      count_low = '0;
      count_high = '0;
      error_total = 0;
      outstanding = 0;
   end

endmodule

@@ dv/pauli_string_multiply_phase_core_tb.sv @@
// Testbench top for the Pauli string product core: clock, reset, stimulus and verdict.
module pauli_string_multiply_phase_core_tb;
   import pspm_pkg::*;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic                      req_tlast = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      rsp_tlast;
   int                        mismatch_count;
   int                        outstanding;

   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   logic hold_off = 1'b0;

   pauli_string_multiply_phase_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   pspm_product_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Receiver: random stalls, forced off during a hold-off stretch
   initial begin
      forever begin
         @(posedge clock);
         rsp_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // One word transfer on the request channel, with random idle cycles ahead of it
   task automatic send_word(input word_type lx, input word_type lz, input word_type rx,
                            input word_type rz, input logic ls, input logic rs,
                            input logic last);
      logic [REQ_TDATA_BITS-1:0] d;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      d = '0;
      d[REQ_LX_LSB +: FIELD_BITS] = lx;
      d[REQ_LZ_LSB +: FIELD_BITS] = lz;
      d[REQ_RX_LSB +: FIELD_BITS] = rx;
      d[REQ_RZ_LSB +: FIELD_BITS] = rz;
      d[REQ_LSIGN_BIT] = ls;
      d[REQ_RSIGN_BIT] = rs;
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Random word: uniform, sparse, dense, all zero or all ones
   function automatic word_type random_word();
      word_type w;
      w = {$urandom, $urandom};
      case ($urandom_range(9))
         0: w = '0;
         1: w = '1;
         2, 3: w = w & {$urandom, $urandom} & {$urandom, $urandom};
         4: w = w | {$urandom, $urandom};
         default: ;
      endcase
      return w;
   endfunction

   // Whole strings of random length, each closed by a last word
   task automatic send_strings(input int n_items);
      int sent;
      int len;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 1);
         for (int w = 0; w < len; w++) begin
            send_word(random_word(), random_word(), random_word(), random_word(),
                      1'($urandom), 1'($urandom), w == len - 1);
         end
         sent += len;
      end
   endtask

   initial begin
      #4000000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, every Pauli pair, sign handling, multi-word strings
      send_word('0, '0, '0, '0, 1'b0, 1'b0, 1'b1);
      send_word('1, '1, '1, '1, 1'b1, 1'b1, 1'b1);
      send_word('1, '0, '0, '1, 1'b0, 1'b0, 1'b1);     // X times Z on all lanes
      send_word('0, '1, '1, '0, 1'b1, 1'b0, 1'b1);     // Z times X on all lanes
      send_word(64'h1, 64'h0, 64'h0, 64'h1, 1'b0, 1'b0, 1'b1);
      send_word(64'h1, 64'h0, 64'h0, 64'h1, 1'b1, 1'b1, 1'b1);
      send_word(64'h1, 64'h1, 64'h1, 64'h0, 1'b0, 1'b0, 1'b1); // Y times X
      send_word(64'h1, 64'h1, 64'h0, 64'h1, 1'b0, 1'b1, 1'b1); // Y times Z
      send_word(64'h1, 64'h0, 64'h1, 64'h1, 1'b1, 1'b0, 1'b1); // X times Y
      send_word(64'h0, 64'h1, 64'h1, 64'h1, 1'b0, 1'b0, 1'b1); // Z times Y
      send_word(64'h8000_0000_0000_0000, 64'h0, 64'h0, 64'h8000_0000_0000_0000,
                1'b0, 1'b0, 1'b1);
      send_word(64'h7, 64'h0, 64'h0, 64'h7, 1'b0, 1'b0, 1'b1); // three anticommuting lanes
      // non-last words carry signs that must be ignored
      send_word(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1, 1'b1, 1'b0);
      send_word(64'hFFFF_0000_FFFF_0000, 64'h0F0F_0F0F_0F0F_0F0F,
                64'h00FF_00FF_00FF_00FF, 64'h3333_3333_3333_3333, 1'b1, 1'b0, 1'b0);
      send_word('1, '0, '0, '1, 1'b0, 1'b1, 1'b1);
      // same lane hit in several words so the high plane counts
      send_word(64'h1, 64'h0, 64'h0, 64'h1, 1'b0, 1'b0, 1'b0);
      send_word(64'h1, 64'h1, 64'h1, 64'h0, 1'b0, 1'b0, 1'b0);
      send_word(64'h0, 64'h1, 64'h1, 64'h1, 1'b0, 1'b0, 1'b0);
      send_word(64'h1, 64'h0, 64'h0, 64'h1, 1'b1, 1'b0, 1'b1);
      send_word('1, '1, '0, '1, 1'b1, 1'b1, 1'b1);

      // Random strings across idling phases
      send_idle_pct = 0;  recv_stall_pct = 0;  send_strings(450);
      send_idle_pct = 51; recv_stall_pct = 0;  send_strings(450);
      send_idle_pct = 0;  recv_stall_pct = 51; send_strings(450);
      send_idle_pct = 16; recv_stall_pct = 16; send_strings(450);

      // Long receiver hold-off while the sender keeps offering words
      send_idle_pct = 0;  recv_stall_pct = 0;
      fork
         begin
            hold_off <= 1'b1;
            repeat (300) @(posedge clock);
            hold_off <= 1'b0;
         end
      join_none
      send_strings(120);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0 && outstanding == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/pspm_pkg.sv
design/pauli_string_multiply_phase_core.sv
dv/pspm_product_checker.sv
dv/pauli_string_multiply_phase_core_tb.sv
